// ===== design/daf_pkg.sv =====
// Shared types and constants of the disk address field decoder.
package daf_pkg;

  localparam int NIB_W   = 8;
  localparam int GAP_W   = 16;
  localparam int POS_W   = 16;
  localparam int FIELD_W = 9;
  localparam int PHASE_W = 4;

  // Prologue bytes of an address field
  localparam logic [NIB_W-1:0] PROLOGUE_1 = 8'hD5;
  localparam logic [NIB_W-1:0] PROLOGUE_2 = 8'hAA;
  localparam logic [NIB_W-1:0] PROLOGUE_3 = 8'h96;

  localparam logic [GAP_W-1:0] GAP_LIMIT_RESET = 16'd40;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 4'd0,
    PH_D5   = 4'd1,
    PH_D5AA = 4'd2,
    PH_VOL1 = 4'd3,
    PH_VOL2 = 4'd4,
    PH_TRK1 = 4'd5,
    PH_TRK2 = 4'd6,
    PH_SEC1 = 4'd7,
    PH_SEC2 = 4'd8,
    PH_DONE = 4'd9
  } phase_t;

  // Parser state carried from one nibble to the next
  typedef struct packed {
    phase_t               phase;
    logic [FIELD_W-1:0]   vol;
    logic [FIELD_W-1:0]   trk;
    logic [FIELD_W-1:0]   sec;
    logic [POS_W-1:0]     d5_pos;
  } parse_st_t;

  // One input beat
  typedef struct packed {
    logic [NIB_W-1:0] nibble;
    logic [GAP_W-1:0] gap;
    logic [POS_W-1:0] bit_pos;
  } nib_beat_t;

endpackage

// ===== design/daf_if.sv =====
// Channel interfaces of the disk address field decoder.
interface daf_in_if;
  logic                        valid;
  logic                        ready;
  logic [daf_pkg::NIB_W-1:0]   nibble;
  logic [daf_pkg::GAP_W-1:0]   gap;
  logic [daf_pkg::POS_W-1:0]   bit_pos;

  modport source (output valid, output nibble, output gap, output bit_pos, input ready);
  modport sink   (input valid, input nibble, input gap, input bit_pos, output ready);
endinterface

interface daf_out_if;
  logic                         valid;
  logic                         ready;
  logic [daf_pkg::PHASE_W-1:0]  parse_state;
  logic [daf_pkg::FIELD_W-1:0]  volume;
  logic [daf_pkg::FIELD_W-1:0]  track_num;
  logic [daf_pkg::FIELD_W-1:0]  sector_num;
  logic [daf_pkg::POS_W-1:0]    header_pos;

  modport source (output valid, output parse_state, output volume, output track_num,
                  output sector_num, output header_pos, input ready);
  modport sink   (input valid, input parse_state, input volume, input track_num,
                  input sector_num, input header_pos, output ready);
endinterface

interface daf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [daf_pkg::GAP_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/daf_parse.sv =====
// Next-state logic of the address field parser for one nibble.
module daf_parse (
  input  daf_pkg::parse_st_t           st_i,
  input  daf_pkg::nib_beat_t           beat_i,
  input  logic [daf_pkg::GAP_W-1:0]    gap_limit_i,
  output daf_pkg::parse_st_t           st_o
);

  daf_pkg::phase_t             cur;
  logic [daf_pkg::FIELD_W-1:0] nib_ext;
  logic [daf_pkg::FIELD_W-1:0] first_half;

  assign nib_ext    = {1'b0, beat_i.nibble};
  assign first_half = {beat_i.nibble, 1'b1};

  always_comb begin
    st_o = st_i;
    cur  = st_i.phase;
    // drop back to idle after a long gap, then handle the nibble
    if (beat_i.gap > gap_limit_i) begin
      cur = daf_pkg::PH_IDLE;
    end
    case (cur)
      daf_pkg::PH_D5: begin
        st_o.phase = (beat_i.nibble == daf_pkg::PROLOGUE_2) ? daf_pkg::PH_D5AA
                                                             : daf_pkg::PH_IDLE;
      end
      daf_pkg::PH_D5AA: begin
        st_o.phase = (beat_i.nibble == daf_pkg::PROLOGUE_3) ? daf_pkg::PH_VOL1
                                                             : daf_pkg::PH_IDLE;
      end
      daf_pkg::PH_VOL1: begin
        st_o.vol   = first_half;
        st_o.phase = daf_pkg::PH_VOL2;
      end
      daf_pkg::PH_VOL2: begin
        st_o.vol   = st_i.vol & nib_ext;
        st_o.phase = daf_pkg::PH_TRK1;
      end
      daf_pkg::PH_TRK1: begin
        st_o.trk   = first_half;
        st_o.phase = daf_pkg::PH_TRK2;
      end
      daf_pkg::PH_TRK2: begin
        st_o.trk   = st_i.trk & nib_ext;
        st_o.phase = daf_pkg::PH_SEC1;
      end
      daf_pkg::PH_SEC1: begin
        st_o.sec   = first_half;
        st_o.phase = daf_pkg::PH_SEC2;
      end
      daf_pkg::PH_SEC2: begin
        st_o.sec   = st_i.sec & nib_ext;
        st_o.phase = daf_pkg::PH_DONE;
      end
      default: begin
        // idle, done and unused codes: look for the first prologue byte
        if (beat_i.nibble == daf_pkg::PROLOGUE_1) begin
          st_o.phase  = daf_pkg::PH_D5;
          st_o.d5_pos = beat_i.bit_pos;
        end else begin
          st_o.phase  = daf_pkg::PH_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== design/disk_address_field_decoder_top.sv =====
// Top level of the disk address field decoder: input stage, parser, result register.
// Usage:
//   in_ch  carries one disk nibble per beat with the gap in clocks since the
//          previous nibble and the nibble's bit position in the track.
//   out_ch returns one beat per input beat: parser phase, volume, track and
//          sector registers, and the bit position of the last D5 byte taken in idle or done.
//   cfg_ch writes gap_limit; write it only while no nibble is in flight.
//          cfg_ch.ready is always high.
// Path: an accepted input beat goes from the input register to the result
//   register, from which the sink takes it; while out_ch stalls, the beat can
//   wait in the input register.
// Throughput: one nibble per cycle while out_ch.ready is high; the parser state
//   is a single register updated by one short logic step, so beats run back to back.
// Reset (rst_n low, synchronous): parser goes idle, its field registers and the
//   D5 position clear, gap_limit returns to 40, both stages empty.
// Stall: while out_ch.ready is low the result register holds its beat; the
//   input register still fills, and in_ch.ready drops only once both stages
//   hold a beat. No beat is lost or repeated.
module disk_address_field_decoder_top (
  input  logic             clk,
  input  logic             rst_n,
  daf_in_if.sink           in_ch,
  daf_out_if.source        out_ch,
  daf_cfg_if.sink          cfg_ch
);

  // Input stage
  logic                        s1_valid_r;
  daf_pkg::nib_beat_t          s1_beat_r;

  // Parser state and configuration
  daf_pkg::parse_st_t          st_r;
  daf_pkg::parse_st_t          st_nxt;
  logic [daf_pkg::GAP_W-1:0]   gap_limit_r;

  // Result register
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  daf_pkg::parse_st_t          out_r;

  logic                        adv_out;
  logic                        fire;
  logic                        in_acc;

  // Advance the result register when it is empty or being taken
  assign adv_out = !out_valid_r || out_ch.ready;
  assign fire    = s1_valid_r && adv_out;
  assign in_acc  = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !s1_valid_r || adv_out;
  assign cfg_ch.ready = 1'b1;

  assign out_valid_nxt = fire || (out_valid_r && !out_ch.ready);

  daf_parse u_parse (
    .st_i        (st_r),
    .beat_i      (s1_beat_r),
    .gap_limit_i (gap_limit_r),
    .st_o        (st_nxt)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      st_r.phase    <= daf_pkg::PH_IDLE;
      st_r.vol      <= '0;
      st_r.trk      <= '0;
      st_r.sec      <= '0;
      st_r.d5_pos   <= '0;
      gap_limit_r   <= daf_pkg::GAP_LIMIT_RESET;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      out_valid_r <= out_valid_nxt;
      // commit the parser step only when its result moves on
      if (fire) begin
        st_r <= st_nxt;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        gap_limit_r <= cfg_ch.data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_beat_r.nibble  <= in_ch.nibble;
      s1_beat_r.gap     <= in_ch.gap;
      s1_beat_r.bit_pos <= in_ch.bit_pos;
    end
    if (fire) begin
      out_r <= st_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.parse_state = out_r.phase;
  assign out_ch.volume      = out_r.vol;
  assign out_ch.track_num   = out_r.trk;
  assign out_ch.sector_num  = out_r.sec;
  assign out_ch.header_pos  = out_r.d5_pos;

  // The latest result always mirrors the committed parser state
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r == st_r))
    else $error("result register differs from parser state");

  // A long gap with a non-D5 nibble always lands in idle
  a_gap_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (s1_beat_r.gap > gap_limit_r) && (s1_beat_r.nibble != daf_pkg::PROLOGUE_1))
    |=> (st_r.phase == daf_pkg::PH_IDLE))
    else $error("long gap did not restart the parser");

  // With the result stage empty the input is always ready
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result stage");

  // After the first volume byte the register holds byte<<1 with bit 0 set
  a_vol_first_half: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == daf_pkg::PH_VOL2) |-> st_r.vol[0])
    else $error("volume first half lost bit 0");

endmodule

// ===== tb/sv/disk_address_field_decoder_top_tb.sv =====
// Self-checking testbench for the disk address field decoder top level.
`timescale 1ns / 100ps

module disk_address_field_decoder_top_tb;
  import daf_pkg::*;

  localparam int PIPE_LAT = 2;   // input register plus result register
  localparam int N_PHASES = 5;
  localparam int PHASE_ITEMS = 200;

  // Tracks the header parser and holds the field sets that the block owes us.
  class header_scoreboard;
    parse_st_t        hdr;
    logic [GAP_W-1:0] gap_limit;
    parse_st_t        owed_fields[$];
    int               errors;
    int               checked;
    int               headers_done;

    function new();
      hdr = '0;
      hdr.phase = PH_IDLE;
      gap_limit = GAP_LIMIT_RESET;
      errors = 0;
      checked = 0;
      headers_done = 0;
    endfunction

    function int pending();
      return owed_fields.size();
    endfunction

    // Advance the parser by one accepted nibble and queue the field set it yields.
    function void note_nibble(logic [NIB_W-1:0] nib, logic [GAP_W-1:0] gap,
                              logic [POS_W-1:0] pos);
      if (gap > gap_limit) hdr.phase = PH_IDLE;
      case (hdr.phase)
        PH_D5:   hdr.phase = (nib == PROLOGUE_2) ? PH_D5AA : PH_IDLE;
        PH_D5AA: hdr.phase = (nib == PROLOGUE_3) ? PH_VOL1 : PH_IDLE;
        PH_VOL1: begin
          hdr.vol = {nib, 1'b1};
          hdr.phase = PH_VOL2;
        end
        PH_VOL2: begin
          hdr.vol = hdr.vol & {1'b0, nib};
          hdr.phase = PH_TRK1;
        end
        PH_TRK1: begin
          hdr.trk = {nib, 1'b1};
          hdr.phase = PH_TRK2;
        end
        PH_TRK2: begin
          hdr.trk = hdr.trk & {1'b0, nib};
          hdr.phase = PH_SEC1;
        end
        PH_SEC1: begin
          hdr.sec = {nib, 1'b1};
          hdr.phase = PH_SEC2;
        end
        PH_SEC2: begin
          hdr.sec = hdr.sec & {1'b0, nib};
          hdr.phase = PH_DONE;
        end
        default: begin
          // idle, done and the unused codes all look for a fresh D5
          if (nib == PROLOGUE_1) begin
            hdr.phase = PH_D5;
            hdr.d5_pos = pos;
          end else begin
            hdr.phase = PH_IDLE;
          end
        end
      endcase
      if (hdr.phase == PH_DONE) headers_done++;
      owed_fields.push_back(hdr);
    endfunction

    // Compare one result beat with the oldest owed field set.
    function void check_result(parse_st_t got);
      parse_st_t want;
      bit        bad;
      checked++;
      if (owed_fields.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] ERROR: result beat with nothing owed: state=%0d vol=%h trk=%h sec=%h pos=%h",
                   $time, got.phase, got.vol, got.trk, got.sec, got.d5_pos);
        return;
      end
      want = owed_fields.pop_front();
      bad = (got.phase !== want.phase) || (got.vol !== want.vol) ||
            (got.trk !== want.trk) || (got.sec !== want.sec) ||
            (got.d5_pos !== want.d5_pos);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] ERROR: exp state=%0d vol=%h trk=%h sec=%h pos=%h",
                   $time, want.phase, want.vol, want.trk, want.sec, want.d5_pos);
          $display("            got state=%0d vol=%h trk=%h sec=%h pos=%h",
                   got.phase, got.vol, got.trk, got.sec, got.d5_pos);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  daf_in_if  in_ch();
  daf_out_if out_ch();
  daf_cfg_if cfg_ch();

  header_scoreboard sb = new();

  // Knobs for idle and stall insertion; cleared for one full-rate phase.
  bit src_idle_en  = 1'b1;
  bit sink_stall_en = 1'b1;

  int nibbles_sent  = 0;
  int headers_sent  = 0;
  int limit_writes  = 0;

  disk_address_field_decoder_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a beat.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Sample every handshake at the rising edge; inputs only move on falling edges.
  always @(posedge clk) begin
    parse_st_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.phase  = phase_t'(out_ch.parse_state);
        got.vol    = out_ch.volume;
        got.trk    = out_ch.track_num;
        got.sec    = out_ch.sector_num;
        got.d5_pos = out_ch.header_pos;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready)
        sb.note_nibble(in_ch.nibble, in_ch.gap, in_ch.bit_pos);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.gap_limit = cfg_ch.data;
    end
  end

  // Result-side backpressure: mostly open, short stalls, now and then a long one.
  initial begin
    int r;
    int len;
    bit lvl;
    out_ch.ready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        lvl = 1'b1;
        len = $urandom_range(1, 24);
      end else if (r < 92) begin
        lvl = 1'b0;
        len = $urandom_range(1, 3);
      end else begin
        lvl = 1'b0;
        len = $urandom_range(10, 40);
      end
      if (!sink_stall_en) lvl = 1'b1;
      repeat (len) begin
        @(negedge clk);
        out_ch.ready <= lvl;
      end
    end
  end

  // Pick how many idle cycles go before the next nibble.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (!src_idle_en || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Gap for a nibble: usually within the limit, sometimes anything, or forced too long.
  function automatic logic [GAP_W-1:0] pick_gap(bit too_long);
    int r;
    r = $urandom_range(0, 99);
    if (too_long && sb.gap_limit != {GAP_W{1'b1}})
      return GAP_W'($urandom_range(int'(sb.gap_limit) + 1, 65535));
    if (r < 85) return GAP_W'($urandom_range(0, int'(sb.gap_limit)));
    return GAP_W'($urandom_range(0, 65535));
  endfunction

  // Present one nibble beat and hold it until accepted. Entered just after a rising edge;
  // valid is left high so a back-to-back beat never drops it.
  task automatic send_nibble(logic [NIB_W-1:0] nib, logic [GAP_W-1:0] gap,
                             logic [POS_W-1:0] pos);
    int idle;
    idle = pick_idle();
    repeat (idle) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.nibble  <= nib;
    in_ch.gap     <= gap;
    in_ch.bit_pos <= pos;
    do @(posedge clk); while (!in_ch.ready);
    nibbles_sent++;
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_gap_limit(logic [GAP_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    limit_writes++;
  endtask

  // One address field with random content: prologue, then 4-and-4 pairs for volume,
  // track and sector. A few pairs are raw bytes; now and then a byte or a gap is spoiled.
  task automatic send_header();
    logic [NIB_W-1:0] bytes [11];
    logic [NIB_W-1:0] v;
    logic [NIB_W-1:0] nib;
    logic [POS_W-1:0] pos;
    bit               too_long;
    bytes[0] = PROLOGUE_1;
    bytes[1] = PROLOGUE_2;
    bytes[2] = PROLOGUE_3;
    for (int k = 0; k < 3; k++) begin
      v = NIB_W'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        bytes[3 + 2*k] = NIB_W'($urandom);
        bytes[4 + 2*k] = NIB_W'($urandom);
      end else begin
        bytes[3 + 2*k] = (v >> 1) | 8'hAA;
        bytes[4 + 2*k] = v | 8'hAA;
      end
    end
    pos = POS_W'($urandom);
    for (int i = 0; i < 11; i++) begin
      nib = bytes[i];
      if ($urandom_range(0, 99) < 3) nib = NIB_W'($urandom);
      too_long = ($urandom_range(0, 99) < 3);
      send_nibble(nib, pick_gap(too_long), pos + POS_W'(8 * i));
    end
    headers_sent++;
  endtask

  // Noise nibble, weighted toward the prologue bytes.
  task automatic send_noise();
    int r;
    logic [NIB_W-1:0] nib;
    r = $urandom_range(0, 99);
    if (r < 15) nib = PROLOGUE_1;
    else if (r < 22) nib = PROLOGUE_2;
    else if (r < 28) nib = PROLOGUE_3;
    else nib = NIB_W'($urandom);
    send_nibble(nib, pick_gap($urandom_range(0, 99) < 5), POS_W'($urandom));
  endtask

  initial begin
    logic [GAP_W-1:0] limits [N_PHASES];
    int target;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.nibble  = '0;
    in_ch.gap     = '0;
    in_ch.bit_pos = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;

    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset gap limit of 40.
    // Full header with extreme byte values and extreme position and gap.
    send_nibble(PROLOGUE_1, 16'd0, 16'hFFFF);
    send_nibble(PROLOGUE_2, 16'd0, 16'h0000);
    send_nibble(PROLOGUE_3, 16'd0, 16'hFFFF);
    send_nibble(8'hFF, 16'd0, 16'h0000);
    send_nibble(8'hFF, 16'd40, 16'h0000);
    send_nibble(8'h00, 16'd0, 16'h0000);
    send_nibble(8'h00, 16'd0, 16'h0000);
    send_nibble(8'hFF, 16'd0, 16'h0000);
    send_nibble(8'h00, 16'd0, 16'h0000);
    // Done acts as idle: D5 restarts the header and records its position.
    send_nibble(PROLOGUE_1, 16'd1, 16'h1234);
    // Wrong prologue: a second D5 falls back to idle.
    send_nibble(PROLOGUE_1, 16'd0, 16'h5555);
    // Non-D5 from idle stays idle.
    send_nibble(8'h12, 16'd0, 16'hAAAA);
    // Wrong third prologue byte.
    send_nibble(PROLOGUE_1, 16'd0, 16'h0F0F);
    send_nibble(PROLOGUE_2, 16'd0, 16'h0000);
    send_nibble(8'h00, 16'd0, 16'h0000);
    // Overlong gap: D5 still starts a header after the forced idle; AA is then dropped.
    send_nibble(PROLOGUE_1, 16'd41, 16'hF0F0);
    send_nibble(PROLOGUE_2, 16'hFFFF, 16'h0000);
    // Gap equal to the limit keeps the header going; stop after the prologue.
    send_nibble(PROLOGUE_1, 16'd0, 16'h00FF);
    send_nibble(PROLOGUE_2, 16'd40, 16'h0000);
    send_nibble(PROLOGUE_3, 16'd40, 16'h0000);
    // A random header, entered with the parser still in the volume phase, then a 00 byte.
    send_header();
    send_nibble(8'h00, 16'd0, 16'h0000);

    // Random phases: reset limit at full rate, then widest, zero, random and back to 40.
    limits[0] = GAP_LIMIT_RESET;
    limits[1] = 16'hFFFF;
    limits[2] = 16'h0000;
    limits[3] = GAP_W'($urandom_range(1, 300));
    limits[4] = GAP_LIMIT_RESET;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      src_idle_en   = (ph != 0);
      sink_stall_en = (ph != 0);
      if (ph > 0) write_gap_limit(limits[ph]);
      target = nibbles_sent + PHASE_ITEMS;
      while (nibbles_sent < target) begin
        if ($urandom_range(0, 99) < 70) send_header();
        else send_noise();
      end
    end

    drain();
    repeat (2 * PIPE_LAT) @(posedge clk);

    $display("Sent %0d nibbles in %0d framed headers over %0d gap limit writes;",
             nibbles_sent, headers_sent, limit_writes);
    $display("checked %0d result beats, %0d headers decoded to done, %0d mismatches.",
             sb.checked, sb.headers_done, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
